>>> src/mmc3_pkg.sv
// Shared types, codes and helpers of the MMC3 bank mapper.
// No dependencies; imported by every module of the block.
package mmc3_pkg;

   localparam int PRG_OFS_BITS = 13;
   localparam int CHR_OFS_BITS = 10;
   localparam int MADDR_BITS   = 21;
   localparam int COUNT_BITS   = 9;
   localparam int BANK_BITS    = 8;

   localparam logic [2:0] REQ_CPU_WR  = 3'd0;
   localparam logic [2:0] REQ_CPU_RD  = 3'd1;
   localparam logic [2:0] REQ_PPU_RD  = 3'd2;
   localparam logic [2:0] REQ_PPU_WR  = 3'd3;
   localparam logic [2:0] REQ_PPU_ADR = 3'd4;
   localparam logic [2:0] REQ_TICK    = 3'd5;

   localparam logic [2:0] TGT_NONE    = 3'd0;
   localparam logic [2:0] TGT_PRG_ROM = 3'd1;
   localparam logic [2:0] TGT_CHR_ROM = 3'd2;
   localparam logic [2:0] TGT_CHR_RAM = 3'd3;
   localparam logic [2:0] TGT_NT_RAM  = 3'd4;

   localparam logic [1:0] MIR_FOUR = 2'd2;

   localparam logic [1:0] CSR_PRG_COUNT = 2'd0;
   localparam logic [1:0] CSR_CHR_COUNT = 2'd1;
   localparam logic [1:0] CSR_CHR_RAM   = 2'd2;
   localparam logic [1:0] CSR_FOUR_SCR  = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] address;
      logic [7:0]  value;
   } req_item_type;

   typedef struct packed {
      logic irq_pulse;
      logic mirroring_changed;
   } event_type;

   typedef logic [7:0][BANK_BITS-1:0] bank_file_type;

   function automatic logic [COUNT_BITS-1:0] clamp_count(input logic [COUNT_BITS-1:0] c);
      logic [COUNT_BITS-1:0] r;
      if (c == '0) begin
         r = COUNT_BITS'(1);
      end else if (c[COUNT_BITS-1] && (c[COUNT_BITS-2:0] != '0)) begin
         r = COUNT_BITS'(256);
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

>>> src/mmc3_bank_mapper_irq.sv
// Top level of the MMC3 bank mapper with scanline IRQ counter.
// Depends on mmc3_pkg, mmc3_regs and mmc3_bank_rem.
//
//  channel | dir | handshake            | payload
//  req_    | in  | tvalid/tready        | tuser: req_type; tdata: address, value
//  rsp_    | out | tvalid/tready        | tuser: target; tdata: result fields
//  csr_    | in  | wr_en, no back-press | index, wdata
//
// An item without a bank lookup passes the exec and done states from accept to result.
// A PRG or CHR ROM read also passes the divide state, where the remainder unit takes one bank bit at a time.
// Reset is synchronous; no clearing pass is needed.
// A held result stalls the block only when the next item finishes first.
module mmc3_bank_mapper_irq (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   input  logic [23:0] req_tdata,   // [15:0] address, [23:16] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] target
   output logic [31:0] rsp_tdata,   // [20:0] mem_address, [21] mem_write, [22] irq_pulse,
                                    // [23] irq_pending, [25:24] mirroring,
                                    // [26] mirroring_changed, [31:27] zero
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import mmc3_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]             state_ff, state_in;
   req_item_type           req_ff;
   logic [COUNT_BITS-1:0]  prg_cnt_ff, chr_cnt_ff;
   logic                   chr_ram_ff, four_ff;

   logic [2:0]             tgt_ff, tgt_in;
   logic [MADDR_BITS-1:0]  base_ff, base_in;
   logic                   mwr_ff, mwr_in;
   event_type              evt_ff;

   logic                   rsp_valid_ff;
   logic [2:0]             rsp_tgt_ff;
   logic [MADDR_BITS-1:0]  rsp_addr_ff;
   logic                   rsp_mwr_ff, rsp_pulse_ff, rsp_pend_ff, rsp_mchg_ff;
   logic [1:0]             rsp_mir_ff;

   logic                   commit;
   bank_file_type          banks;
   logic                   prg_swap, chr_invert, irq_raised;
   logic [1:0]             mirror;
   event_type              evt;

   logic                   div_start, div_busy;
   logic [BANK_BITS-1:0]   dividend, remainder;
   logic [COUNT_BITS-1:0]  divisor, prg_cnt, chr_cnt;
   logic [BANK_BITS-1:0]   second_last, last_bank, prg_bank, chr_bank, chr_reg;
   logic [2:0]             chr_slot, chr_idx;
   logic                   out_free;
   logic [MADDR_BITS-1:0]  final_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_cnt_ff <= COUNT_BITS'(16);
         chr_cnt_ff <= COUNT_BITS'(128);
         chr_ram_ff <= 1'b0;
         four_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PRG_COUNT: prg_cnt_ff <= csr_wdata;
            CSR_CHR_COUNT: chr_cnt_ff <= csr_wdata;
            CSR_CHR_RAM:   chr_ram_ff <= csr_wdata[0];
            CSR_FOUR_SCR:  four_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign commit     = (state_ff == ST_EXEC);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   mmc3_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .commit     (commit),
      .req        (req_ff),
      .four_screen(four_ff),
      .banks      (banks),
      .prg_swap   (prg_swap),
      .chr_invert (chr_invert),
      .mirror     (mirror),
      .irq_raised (irq_raised),
      .evt        (evt)
   );

   // bank lookup for the captured request
   always_comb begin
      prg_cnt     = clamp_count(prg_cnt_ff);
      chr_cnt     = clamp_count(chr_cnt_ff);
      second_last = (prg_cnt >= COUNT_BITS'(2)) ? BANK_BITS'(prg_cnt - COUNT_BITS'(2)) : '0;
      last_bank   = BANK_BITS'(prg_cnt - COUNT_BITS'(1));
      case (req_ff.address[14:13])
         2'd0:    prg_bank = prg_swap ? second_last : banks[6];
         2'd1:    prg_bank = banks[7];
         2'd2:    prg_bank = prg_swap ? banks[6] : second_last;
         default: prg_bank = last_bank;
      endcase
      chr_slot = req_ff.address[12:10] ^ {chr_invert, 2'b00};
      chr_idx  = chr_slot[2] ? chr_slot - 3'd2 : {2'b00, chr_slot[1]};
      chr_reg  = banks[chr_idx];
      if (chr_slot[2]) begin
         chr_bank = chr_reg;
      end else if (chr_slot[0]) begin
         chr_bank = chr_reg | 8'h01;
      end else begin
         chr_bank = chr_reg & 8'hfe;
      end
   end

   // classify the request
   always_comb begin
      tgt_in    = TGT_NONE;
      base_in   = '0;
      mwr_in    = 1'b0;
      div_start = 1'b0;
      dividend  = prg_bank;
      divisor   = prg_cnt;
      case (req_ff.req_type) inside
         REQ_CPU_RD: begin
            if (req_ff.address[15]) begin
               tgt_in    = TGT_PRG_ROM;
               base_in   = MADDR_BITS'(req_ff.address[PRG_OFS_BITS-1:0]);
               div_start = commit;
            end
         end
         REQ_PPU_RD, REQ_PPU_WR: begin
            if (req_ff.address[15:13] == 3'd0) begin
               if (chr_ram_ff) begin
                  tgt_in  = TGT_CHR_RAM;
                  base_in = MADDR_BITS'(req_ff.address);
                  mwr_in  = (req_ff.req_type == REQ_PPU_WR);
               end else if (req_ff.req_type == REQ_PPU_RD) begin
                  tgt_in    = TGT_CHR_ROM;
                  base_in   = MADDR_BITS'(req_ff.address[CHR_OFS_BITS-1:0]);
                  dividend  = chr_bank;
                  divisor   = chr_cnt;
                  div_start = commit;
               end
            end else if (req_ff.address[15:12] == 4'd2) begin
               tgt_in  = TGT_NT_RAM;
               base_in = MADDR_BITS'(req_ff.address[11:0]);
               mwr_in  = (req_ff.req_type == REQ_PPU_WR);
            end
         end
         default: begin
         end
      endcase
   end

   mmc3_bank_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .remainder(remainder)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_EXEC;
         ST_EXEC: state_in = div_start ? ST_DIV : ST_DONE;
         ST_DIV:  if (!div_busy) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case (tgt_ff)
         TGT_PRG_ROM: final_addr = {remainder, base_ff[PRG_OFS_BITS-1:0]};
         TGT_CHR_ROM: final_addr = MADDR_BITS'({remainder, base_ff[CHR_OFS_BITS-1:0]});
         default:     final_addr = base_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff.req_type <= req_tuser;
         req_ff.address  <= req_tdata[15:0];
         req_ff.value    <= req_tdata[23:16];
      end
      if (commit) begin
         tgt_ff  <= tgt_in;
         base_ff <= base_in;
         mwr_ff  <= mwr_in;
         evt_ff  <= evt;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_tgt_ff   <= tgt_ff;
         rsp_addr_ff  <= final_addr;
         rsp_mwr_ff   <= mwr_ff;
         rsp_pulse_ff <= evt_ff.irq_pulse;
         rsp_pend_ff  <= irq_raised;
         rsp_mir_ff   <= mirror;
         rsp_mchg_ff  <= evt_ff.mirroring_changed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_tgt_ff;
   assign rsp_tdata  = {5'b0, rsp_mchg_ff, rsp_mir_ff, rsp_pend_ff, rsp_pulse_ff,
                        rsp_mwr_ff, rsp_addr_ff};

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result loaded outside done state");

   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == ST_DIV)
      else $error("remainder unit busy outside divide state");

   a_pulse_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pulse_ff) |-> rsp_pend_ff)
      else $error("irq pulse without pending flag");

   a_write_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mwr_ff) |-> (rsp_tgt_ff == TGT_CHR_RAM || rsp_tgt_ff == TGT_NT_RAM))
      else $error("write beat to read-only target");

endmodule

>>> src/mmc3_bank_rem.sv
// Iterative remainder unit: bank number modulo bank count, one bit a cycle.
// Depends on mmc3_pkg.
module mmc3_bank_rem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mmc3_pkg::BANK_BITS-1:0]    dividend,
   input  logic [mmc3_pkg::COUNT_BITS-1:0]   divisor,
   output logic                              busy,
   output logic [mmc3_pkg::BANK_BITS-1:0]    remainder
);
   import mmc3_pkg::*;

   localparam int CNT_BITS = $clog2(BANK_BITS);

   logic                   busy_ff, busy_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [BANK_BITS-1:0]   rem_ff, rem_in;
   logic [BANK_BITS-1:0]   dvd_ff, dvd_in;
   logic [COUNT_BITS-1:0]  div_ff, div_in;
   logic [COUNT_BITS-1:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      trial   = {rem_ff, dvd_ff[BANK_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= div_ff) begin
            rem_in = BANK_BITS'(trial - div_ff);
         end else begin
            rem_in = trial[BANK_BITS-1:0];
         end
         dvd_in = {dvd_ff[BANK_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(BANK_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

>>> src/mmc3_regs.sv
// Mapper register file: bank registers, modes and the scanline IRQ counter.
// Depends on mmc3_pkg.
module mmc3_regs (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       commit,
   input  mmc3_pkg::req_item_type     req,
   input  logic                       four_screen,
   output mmc3_pkg::bank_file_type    banks,
   output logic                       prg_swap,
   output logic                       chr_invert,
   output logic [1:0]                 mirror,
   output logic                       irq_raised,
   output mmc3_pkg::event_type        evt
);
   import mmc3_pkg::*;

   bank_file_type banks_ff, banks_in;
   logic [2:0]    sel_ff, sel_in;
   logic          prg_ff, prg_in;
   logic          chr_ff, chr_in;
   logic [1:0]    mir_ff, mir_in;
   logic [7:0]    latch_ff, latch_in;
   logic [7:0]    count_ff, count_in;
   logic          reload_ff, reload_in;
   logic          en_ff, en_in;
   logic          raised_ff, raised_in;
   logic          a12_ff, a12_in;
   logic          step;
   logic          odd;

   always_comb begin
      banks_in  = banks_ff;
      sel_in    = sel_ff;
      prg_in    = prg_ff;
      chr_in    = chr_ff;
      mir_in    = mir_ff;
      latch_in  = latch_ff;
      count_in  = count_ff;
      reload_in = reload_ff;
      en_in     = en_ff;
      raised_in = raised_ff;
      a12_in    = a12_ff;
      evt       = '0;
      step      = 1'b0;
      odd       = req.address[0];
      unique case (req.req_type)
         REQ_CPU_WR: begin
            if (req.address[15]) begin
               unique case (req.address[14:13])
                  2'd0: begin
                     if (!odd) begin
                        sel_in = req.value[2:0];
                        prg_in = req.value[6];
                        chr_in = req.value[7];
                     end else begin
                        banks_in[sel_ff] = req.value;
                     end
                  end
                  2'd1: begin
                     if (!odd) begin
                        mir_in = four_screen ? MIR_FOUR : {1'b0, req.value[0]};
                        evt.mirroring_changed = 1'b1;
                     end
                  end
                  2'd2: begin
                     if (!odd) begin
                        latch_in = req.value;
                     end else begin
                        count_in  = '0;
                        reload_in = 1'b1;
                     end
                  end
                  default: begin
                     if (!odd) begin
                        en_in     = 1'b0;
                        raised_in = 1'b0;
                     end else begin
                        en_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         REQ_PPU_ADR: begin
            step   = !a12_ff && req.address[12];
            a12_in = req.address[12];
         end
         REQ_TICK: begin
            if (raised_ff) begin
               evt.irq_pulse = 1'b1;
            end else begin
               step = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (step) begin
         count_in = ((count_ff == '0) || reload_ff) ? latch_ff : count_ff - 8'd1;
         if ((count_in == '0) && en_ff) begin
            raised_in = 1'b1;
         end
         reload_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         banks_ff  <= '0;
         sel_ff    <= '0;
         prg_ff    <= 1'b0;
         chr_ff    <= 1'b0;
         mir_ff    <= '0;
         latch_ff  <= '0;
         count_ff  <= '0;
         reload_ff <= 1'b0;
         en_ff     <= 1'b0;
         raised_ff <= 1'b0;
         a12_ff    <= 1'b0;
      end else if (commit) begin
         banks_ff  <= banks_in;
         sel_ff    <= sel_in;
         prg_ff    <= prg_in;
         chr_ff    <= chr_in;
         mir_ff    <= mir_in;
         latch_ff  <= latch_in;
         count_ff  <= count_in;
         reload_ff <= reload_in;
         en_ff     <= en_in;
         raised_ff <= raised_in;
         a12_ff    <= a12_in;
      end
   end

   assign banks      = banks_ff;
   assign prg_swap   = prg_ff;
   assign chr_invert = chr_ff;
   assign mirror     = mir_ff;
   assign irq_raised = raised_ff;

endmodule
